@@ design/deq_pkg.sv @@
package deq_pkg;

  // Queue geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Operation codes carried by the opcode field.
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;

  // Action broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_BACK,
    CELL_PUSH_FRONT,
    CELL_POP_BACK,
    CELL_POP_FRONT
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [DATA_WIDTH-1:0]  value;
  } cell_ctl_t;

endpackage

@@ design/deq_cell.sv @@
module deq_cell
  import deq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] prev_word,
  input  logic                  prev_occ,
  input  logic [DATA_WIDTH-1:0] next_word,
  input  logic                  next_occ,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  occ,
  output logic                  is_back
);

  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic                  occ_r, occ_nxt;

  // The row is a thermometer of occupied cells; the front is cell zero.
  always_comb begin
    word_nxt = word_r;
    occ_nxt  = occ_r;
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_PUSH_BACK: begin
        // The first empty cell takes the new word.
        if (!occ_r && prev_occ) begin
          word_nxt = ctl.value;
          occ_nxt  = 1'b1;
        end
      end
      CELL_PUSH_FRONT: begin
        word_nxt = prev_word;
        occ_nxt  = prev_occ;
      end
      CELL_POP_BACK: begin
        // The last occupied cell lets go of its word.
        if (occ_r && !next_occ) begin
          occ_nxt = 1'b0;
        end
      end
      CELL_POP_FRONT: begin
        word_nxt = next_word;
        occ_nxt  = next_occ;
      end
      default: begin
      end
    endcase
  end

  // Occupancy is control state; the word is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign occ     = occ_r;
  assign is_back = occ_r && !next_occ;

endmodule

@@ design/double_ended_queue.sv @@
// Bounded double-ended queue of up to DEPTH data words.
// Input channel: in_valid/in_ready with in_opcode and in_push_value. The
// opcode selects push back, push front, pop back, pop front or query; codes
// beyond query act as a query.
// Result channel: out_valid/out_ready with the front and back words, the
// occupancy and an error flag. Every input transfer gives exactly one result.
// A push on a full queue or a pop on an empty one changes nothing and sets
// out_op_error. Front and back read as zero when the queue is empty.
// Latency: the result is offered in the cycle after the input transfer.
// Throughput: one item per cycle while the receiver keeps up, set by the
// row of cells, which all shift or load together; the result slot holds
// one item. A new input transfer is taken in the same cycle the pending
// result is transferred. While the receiver stalls, in_ready stays low and
// the queue state holds.
// Reset (rst_n, synchronous, active low) empties the queue and drops any
// pending result; stored words are not cleared.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic [DATA_WIDTH-1:0] in_push_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_front_value,
  output logic [DATA_WIDTH-1:0] out_back_value,
  output logic [CNT_W-1:0]      out_occupancy,
  output logic                  out_op_error
);

  logic                  out_valid_r, out_valid_nxt;
  logic                  err_r, err_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  in_xfer;
  logic                  is_full, is_empty;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] word_w      [DEPTH];
  logic                  occ_w       [DEPTH];
  logic                  back_w      [DEPTH];
  logic [DATA_WIDTH-1:0] prev_word_w [DEPTH];
  logic                  prev_occ_w  [DEPTH];
  logic [DATA_WIDTH-1:0] next_word_w [DEPTH];
  logic                  next_occ_w  [DEPTH];
  logic [DATA_WIDTH-1:0] back_value;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Decode the operation into one action for the row, refusing bad ones.
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = in_push_value;
    err_nxt   = err_r;
    count_nxt = count_r;
    if (in_xfer) begin
      err_nxt = 1'b0;
      unique case (in_opcode) inside
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (is_full) begin
            err_nxt = 1'b1;
          end else begin
            ctl.op    = (in_opcode == OP_PUSH_BACK) ? CELL_PUSH_BACK : CELL_PUSH_FRONT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (is_empty) begin
            err_nxt = 1'b1;
          end else begin
            ctl.op    = (in_opcode == OP_POP_BACK) ? CELL_POP_BACK : CELL_POP_FRONT;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The result slot is full after a transfer until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
      count_r     <= count_nxt;
    end
  end

  // Neighbor links of the row; the ends see the new word and an empty slot.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prev_word_w[gi] = in_push_value;
        assign prev_occ_w[gi]  = 1'b1;
      end else begin : g_mid_lo
        assign prev_word_w[gi] = word_w[gi-1];
        assign prev_occ_w[gi]  = occ_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign next_word_w[gi] = '0;
        assign next_occ_w[gi]  = 1'b0;
      end else begin : g_mid_hi
        assign next_word_w[gi] = word_w[gi+1];
        assign next_occ_w[gi]  = occ_w[gi+1];
      end

      deq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .prev_word (prev_word_w[gi]),
        .prev_occ  (prev_occ_w[gi]),
        .next_word (next_word_w[gi]),
        .next_occ  (next_occ_w[gi]),
        .word      (word_w[gi]),
        .occ       (occ_w[gi]),
        .is_back   (back_w[gi])
      );
    end
  endgenerate

  // Exactly one cell flags itself as the back; none when empty.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (word_w[i] & {DATA_WIDTH{back_w[i]}});
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = occ_w[0] ? word_w[0] : '0;
  assign out_back_value  = back_value;
  assign out_occupancy   = count_r;
  assign out_op_error    = err_r;

endmodule

@@ tb/sv/tb_double_ended_queue.sv @@
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import deq_pkg::*;

  // Codes past query; the block treats them as a query.
  localparam logic [2:0] OP_RESERVED_A = 3'd5;
  localparam logic [2:0] OP_RESERVED_C = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [2:0]            opcode;
    logic [DATA_WIDTH-1:0] value;
  } stim_item_t;

  typedef struct {
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
    logic [CNT_W-1:0]      count;
    logic                  err;
  } deq_view_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            in_opcode = OP_QUERY;
  logic [DATA_WIDTH-1:0] in_push_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DATA_WIDTH-1:0] out_front_value;
  logic [DATA_WIDTH-1:0] out_back_value;
  logic [CNT_W-1:0]      out_occupancy;
  logic                  out_op_error;

  // Items waiting to be offered and snapshots waiting to be seen.
  stim_item_t op_backlog[$];
  deq_view_t  pending_views[$];

  // Shadow copy of the queue contents.
  logic [DATA_WIDTH-1:0] shadow_store[DEPTH];
  int shadow_head = 0;
  int shadow_tail = 0;
  int shadow_count = 0;

  int  mismatch_count = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  logic in_taken = 1'b0;

  double_ended_queue uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_front_value(out_front_value),
    .out_back_value (out_back_value),
    .out_occupancy  (out_occupancy),
    .out_op_error   (out_op_error)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow queue and return the view afterwards.
  function automatic deq_view_t deque_apply(logic [2:0] op, logic [DATA_WIDTH-1:0] val);
    deq_view_t v;
    v.err = 1'b0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          v.err = 1'b1;
        end else if (op == OP_PUSH_BACK) begin
          shadow_store[shadow_tail] = val;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_count++;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = val;
          shadow_count++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          v.err = 1'b1;
        end else if (op == OP_POP_BACK) begin
          shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
          shadow_count--;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_count != 0) begin
      v.front = shadow_store[shadow_head];
      v.back  = shadow_store[(shadow_tail + DEPTH - 1) % DEPTH];
    end else begin
      v.front = '0;
      v.back  = '0;
    end
    v.count = CNT_W'(shadow_count);
    return v;
  endfunction

  // Append one item to the end of the backlog.
  function automatic void add_item(logic [2:0] op, logic [DATA_WIDTH-1:0] val);
    stim_item_t item;
    item.opcode = op;
    item.value  = val;
    op_backlog.insert(op_backlog.size(), item);
  endfunction

  // Data word with a bias toward the extremes.
  function automatic logic [DATA_WIDTH-1:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 30) return DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
    return DATA_WIDTH'($urandom);
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string field, logic [DATA_WIDTH-1:0] exp_val,
                                 logic [DATA_WIDTH-1:0] act_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s at %0t: expected %h, got %h", field, $realtime, exp_val,
               act_val);
  endtask

  // Input driver: offers backlog items with random gaps between them.
  always @(negedge clk) begin : drive_input
    stim_item_t nxt;
    static int send_gap = 0;
    static bit send_steady = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Hold the current item until its transfer.
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (op_backlog.size() > 0) begin
      nxt = op_backlog[0];
      op_backlog.delete(0);
      in_valid      <= 1'b1;
      in_opcode     <= nxt.opcode;
      in_push_value <= nxt.value;
      if ($urandom_range(0, 47) == 0) send_steady = !send_steady;
      send_gap = send_steady ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls, plus a long hold-off now and then so the
  // block backs up and drops in_ready.
  always @(negedge clk) begin : drive_ready
    static int hold_left = 0;
    static int hold_mark = 150;
    static int ready_gap = 0;
    static bit recv_steady = 1'b0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (results_seen >= hold_mark) begin
      hold_left = HOLD_OFF_CYCLES - 1;
      hold_mark = hold_mark + 300;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
      if (!recv_steady && $urandom_range(0, 99) < 25) ready_gap = pick_gap();
    end
  end

  // Monitor: checks each result transfer, then predicts from each input transfer.
  always @(posedge clk) begin : watch_ports
    deq_view_t exp_view;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_views.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result at %0t: front %h back %h count %0d error %b",
                     $realtime, out_front_value, out_back_value, out_occupancy,
                     out_op_error);
        end else begin
          exp_view = pending_views[0];
          pending_views.delete(0);
          if (out_front_value !== exp_view.front)
            report_mismatch("front_value", exp_view.front, out_front_value);
          if (out_back_value !== exp_view.back)
            report_mismatch("back_value", exp_view.back, out_back_value);
          if (out_occupancy !== exp_view.count)
            report_mismatch("occupancy", DATA_WIDTH'(exp_view.count),
                            DATA_WIDTH'(out_occupancy));
          if (out_op_error !== exp_view.err)
            report_mismatch("op_error", DATA_WIDTH'(exp_view.err), DATA_WIDTH'(out_op_error));
        end
      end
      if (in_valid && in_ready)
        pending_views.insert(pending_views.size(), deque_apply(in_opcode, in_push_value));
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) stall_cycles <= 0;
    else if (rst_n) stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int run_len;
    int push_pct;
    int r;
    logic [2:0] op;

    // Directed part: the empty queue, reserved codes, a single element
    // popped from either end, a fill to full and pushes refused when full.
    add_item(OP_QUERY, '1);
    add_item(OP_POP_BACK, '0);
    add_item(OP_POP_FRONT, '1);
    for (int c = OP_RESERVED_A; c <= OP_RESERVED_C; c++)
      add_item(3'(c), rand_word());
    add_item(OP_PUSH_BACK, '1);
    add_item(OP_POP_FRONT, '0);
    add_item(OP_PUSH_FRONT, '0);
    add_item(OP_POP_BACK, '1);
    for (int k = 0; k < DEPTH; k++) begin
      op = (k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      case (k)
        0: add_item(op, '1);
        1: add_item(op, '0);
        2: add_item(op, {(DATA_WIDTH / 2){2'b10}});
        3: add_item(op, {(DATA_WIDTH / 2){2'b01}});
        default: add_item(op, rand_word());
      endcase
    end
    add_item(OP_PUSH_BACK, rand_word());
    add_item(OP_PUSH_FRONT, rand_word());
    add_item(OP_QUERY, '0);

    // Random part: runs that lean toward filling, draining or neither, so the
    // queue keeps hitting full and empty and the indices wrap both ways.
    while (op_backlog.size() < 720) begin
      run_len = $urandom_range(10, 60);
      case ($urandom_range(0, 4))
        0: push_pct = 85;
        1: push_pct = 15;
        2: push_pct = 65;
        3: push_pct = 35;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < run_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) op = OP_QUERY;
        else if (r < 7) op = 3'($urandom_range(OP_RESERVED_A, OP_RESERVED_C));
        else if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        add_item(op, rand_word());
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every item to transfer, then for every result to arrive.
    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/deq_pkg.sv
design/deq_cell.sv
design/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
